>>> hdl/swt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shell word tokenizer.
// No dependencies; imported by every module of the block.
package swt_pkg;

  // Word length bound; the counter saturates at MAX_WORD_LEN - 1, at most 4095
  localparam int MAX_WORD_LEN = 4096;

  localparam int LEN_W   = 12;
  localparam int LINE_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;

  localparam int LEN_CAP_INT = ((MAX_WORD_LEN - 1) < 4095) ? (MAX_WORD_LEN - 1) : 4095;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR      = 3'd0,
    KIND_WORD_END  = 3'd1,
    KIND_LINE_END  = 3'd2,
    KIND_INPUT_END = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  ch;
    logic [LEN_W-1:0]   len;
    logic [LINE_W-1:0]  lines;
  } res_t;

  // All results caused by one input item (one or two)
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } job_t;

  function automatic res_t mk_res(input kind_t kind, input logic [CHAR_W-1:0] ch,
                                  input logic [LEN_W-1:0] len,
                                  input logic [LINE_W-1:0] lines);
    res_t r;
    r.kind  = kind;
    r.ch    = ch;
    r.len   = len;
    r.lines = lines;
    return r;
  endfunction

endpackage

>>> hdl/swt_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks tokenizer state and builds the results
// of each item as one queue entry. Depends on swt_pkg.
module swt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             in_end_of_input,
  input  logic             q_full,
  output logic             in_stall,
  output logic             push,
  output swt_pkg::job_t    job
);
  import swt_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_COMMENT = 2'd1,
    PH_WORD    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  phase_t            phase_r, phase_nxt;
  quote_t            quote_r, quote_nxt;
  logic              esc_r, esc_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LINE_W-1:0] nl_r, nl_nxt;

  logic              accept;
  logic              has_res;
  logic              word_go;
  logic              is_sp, is_lf, q_match, keep_bs;
  logic [LINE_W-1:0] nl_inc;
  logic [LEN_W-1:0]  len_a, len_b;

  function automatic logic [LEN_W-1:0] len_sat(input logic [LEN_W-1:0] x);
    return (x < LEN_CAP) ? x + 1'b1 : x;
  endfunction

  // Classify the byte
  assign is_lf  = (in_byte == CH_LF);
  assign is_sp  = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || is_lf ||
                  (in_byte == CH_VT) || (in_byte == CH_FF) || (in_byte == CH_CR);
  assign q_match = ((quote_r == Q_SINGLE) && (in_byte == CH_SQUOTE)) ||
                   ((quote_r == Q_DOUBLE) && (in_byte == CH_DQUOTE));
  assign keep_bs = esc_r && (quote_r != Q_NONE) && (in_byte != CH_BSLASH) && !q_match;
  assign nl_inc  = nl_r + 1'b1;
  assign len_a   = len_sat(len_r);
  assign len_b   = len_sat(len_a);

  // Next state and results of the item
  always_comb begin
    phase_nxt = phase_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    len_nxt   = len_r;
    nl_nxt    = nl_r;
    job       = '0;
    has_res   = 1'b0;
    word_go   = 1'b0;

    if (in_end_of_input) begin
      has_res = 1'b1;
      if ((phase_r == PH_WORD) && (esc_r || (quote_r != Q_NONE))) begin
        job.r0 = mk_res(KIND_ERROR, CH_NUL, len_r, nl_r);
      end else if (phase_r == PH_WORD) begin
        job.two = 1'b1;
        job.r0  = mk_res(KIND_WORD_END, CH_NUL, len_r, nl_r);
        job.r1  = mk_res(KIND_INPUT_END, CH_NUL, '0, nl_r);
      end else begin
        job.r0 = mk_res(KIND_INPUT_END, CH_NUL, '0, nl_r);
      end
      phase_nxt = PH_SKIP;
      quote_nxt = Q_NONE;
      esc_nxt   = 1'b0;
      len_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_WORD: begin
          word_go = 1'b1;
        end
        PH_COMMENT: begin
          if (is_lf) begin
            nl_nxt    = nl_inc;
            has_res   = 1'b1;
            job.r0    = mk_res(KIND_LINE_END, CH_NUL, len_r, nl_inc);
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (in_byte == CH_NUL) begin
            // drop
          end else if (is_lf) begin
            nl_nxt = nl_inc;
            if (esc_r) begin
              esc_nxt = 1'b0;
            end else begin
              has_res = 1'b1;
              job.r0  = mk_res(KIND_LINE_END, CH_NUL, len_r, nl_inc);
            end
          end else if (esc_r || ((in_byte != CH_HASH) && (in_byte != CH_BSLASH) && !is_sp)) begin
            phase_nxt = PH_WORD;
            word_go   = 1'b1;
          end else if (in_byte == CH_HASH) begin
            phase_nxt = PH_COMMENT;
          end else if (in_byte == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase
    end

    // Byte inside a word
    if (word_go) begin
      if ((in_byte == CH_NUL) && (quote_r == Q_NONE)) begin
        // drop
      end else if (is_sp && (quote_r == Q_NONE) && !esc_r) begin
        has_res   = 1'b1;
        job.r0    = mk_res(KIND_WORD_END, CH_NUL, len_r, nl_r);
        len_nxt   = '0;
        phase_nxt = PH_SKIP;
        if (is_lf) begin
          nl_nxt  = nl_inc;
          job.two = 1'b1;
          job.r1  = mk_res(KIND_LINE_END, CH_NUL, '0, nl_inc);
        end
      end else if ((in_byte == CH_BSLASH) && !esc_r && (quote_r != Q_SINGLE)) begin
        esc_nxt = 1'b1;
      end else if (((in_byte == CH_SQUOTE) || (in_byte == CH_DQUOTE)) &&
                   (quote_r == Q_NONE) && !esc_r) begin
        quote_nxt = (in_byte == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
      end else if (q_match && !esc_r) begin
        quote_nxt = Q_NONE;
      end else if (is_lf && esc_r) begin
        esc_nxt = 1'b0;
        nl_nxt  = nl_inc;
      end else begin
        has_res = 1'b1;
        if (keep_bs) begin
          job.two = 1'b1;
          job.r0  = mk_res(KIND_CHAR, CH_BSLASH, len_a, nl_r);
          job.r1  = mk_res(KIND_CHAR, in_byte, len_b, nl_r);
          len_nxt = len_b;
        end else begin
          job.r0  = mk_res(KIND_CHAR, in_byte, len_a, nl_r);
          len_nxt = len_a;
        end
        esc_nxt = 1'b0;
        if (is_lf) begin
          nl_nxt = nl_inc;
        end
      end
    end
  end

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign push     = accept && has_res;

  // Hold state, advance on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      quote_r <= Q_NONE;
      esc_r   <= 1'b0;
      len_r   <= '0;
      nl_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      len_r   <= len_nxt;
      nl_r    <= nl_nxt;
    end
  end

  // End of input leaves a clean tokenizer
  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_input |=> (phase_r == PH_SKIP) && !esc_r &&
                                  (quote_r == Q_NONE) && (len_r == '0))
    else $error("tokenizer state not cleared after end of input");

  // Quotes are open only inside a word, and the word length stays within its cap
  a_quote_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    (quote_r != Q_NONE) |-> (phase_r == PH_WORD) && (len_r <= LEN_CAP))
    else $error("quote open outside a word or length over cap");

endmodule

>>> hdl/swt_queue.sv
`timescale 1ns / 1ps
// Short queue of result entries between front and back.
// Depends on swt_pkg.
module swt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  swt_pkg::job_t  push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output swt_pkg::job_t  head_job
);
  import swt_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_pop;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");

endmodule

>>> hdl/swt_back.sv
`timescale 1ns / 1ps
// Back end: takes queue entries and presents their one or two results
// through an output register. Depends on swt_pkg.
module swt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  swt_pkg::job_t  head_job,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output swt_pkg::res_t  out_res,
  output logic           out_last
);
  import swt_pkg::*;

  logic out_valid_r;
  logic out_last_r;
  res_t out_res_r;
  logic sec_valid_r;
  res_t sec_r;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = out_free && !sec_valid_r && head_valid;

  // Control: output valid and pending second result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (out_free) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else if (head_valid) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= head_job.two;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: load next result into the output register
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sec_valid_r) begin
        out_res_r  <= sec_r;
        out_last_r <= 1'b1;
      end else if (head_valid) begin
        out_res_r  <= head_job.r0;
        out_last_r <= !head_job.two;
        sec_r      <= head_job.r1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

  a_sec_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> out_valid_r && !out_last_r)
    else $error("second result pending without its first on the output");

  a_first_needs_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> sec_valid_r)
    else $error("non-final result shown with no second result pending");

endmodule

>>> hdl/shell_quoted_word_tokenizer_unit.sv
`timescale 1ns / 1ps
// Shell word tokenizer top level: front end, result queue, back end.
// Depends on swt_pkg, swt_front, swt_queue and swt_back.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | input     | in_valid / in_stall  | in_byte, in_end_of_input
//   out     | output    | out_valid / out_stall| out_kind, out_char, out_word_length,
//           |           |                     | out_line_count, out_last
//
// One byte is taken per cycle while the four-entry result queue has room.
// An item with two results occupies the output register for both in turn, so the
// output register sets the sustained rate: one result per cycle while out_stall is low.
// The first result of an item passes through the queue and then the output register.
// Reset is synchronous, active low, and clears the control state; queue slots and result payloads are not reset.
// A stall on the output fills the queue; in_stall rises only when it is full.
module shell_quoted_word_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_char,
  output logic [11:0] out_word_length,
  output logic [15:0] out_line_count,
  output logic        out_last
);
  import swt_pkg::*;

  logic push, pop, q_full, head_valid;
  job_t push_job, head_job;
  res_t out_res;

  swt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .in_stall        (in_stall),
    .push            (push),
    .job             (push_job)
  );

  swt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  swt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .out_last   (out_last)
  );

  // Unpack result fields onto ports
  assign out_kind        = out_res.kind;
  assign out_char        = out_res.ch;
  assign out_word_length = out_res.len;
  assign out_line_count  = out_res.lines;

endmodule

>>> dv/swt_token_checker.sv
`timescale 1ns / 1ps
// Result checker for the shell word tokenizer: predicts result items from accepted
// input items and compares every accepted output item in order. Depends on swt_pkg.
module swt_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_char,
  input  logic [11:0] out_word_length,
  input  logic [15:0] out_line_count,
  input  logic        out_last,
  output int          fail_count,
  output int          tokens_pending,
  output int          tokens_checked
);
  import swt_pkg::*;

  typedef enum logic [1:0] {SCAN_GAP, SCAN_COMMENT, SCAN_WORD} scan_t;
  typedef enum logic [1:0] {QUOTE_NONE, QUOTE_SINGLE, QUOTE_DOUBLE} quote_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  ch;
    logic [LEN_W-1:0]   len;
    logic [LINE_W-1:0]  lines;
    logic               last;
  } token_t;

  token_t expected_tokens[$];

  // Tokenizer state as the predictor sees it
  scan_t              scan_phase;
  logic               in_escape;
  quote_t             quote;
  logic [LEN_W-1:0]   word_len;
  logic [LINE_W-1:0]  newline_count;
  int                 step_tokens;
  int                 mismatches = 0;
  int                 checked = 0;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  task automatic emit_token(input kind_t k, input logic [7:0] c);
    token_t t;
    t.kind  = k;
    t.ch    = c;
    t.len   = word_len;
    t.lines = newline_count;
    t.last  = 1'b0;
    expected_tokens.push_back(t);
    step_tokens++;
  endtask

  task automatic add_char(input logic [7:0] c);
    if (word_len < LEN_CAP) word_len = word_len + 1'b1;
    emit_token(KIND_CHAR, c);
  endtask

  // Advance the word state by one byte
  task automatic word_byte(input logic [7:0] c);
    logic [8:0] close_mark;
    close_mark = (quote == QUOTE_SINGLE) ? {1'b0, CH_SQUOTE} :
                 (quote == QUOTE_DOUBLE) ? {1'b0, CH_DQUOTE} : 9'h100;
    if (c == CH_NUL && quote == QUOTE_NONE) begin
      // drop NUL outside quotes
    end else if (is_blank(c) && quote == QUOTE_NONE && !in_escape) begin
      emit_token(KIND_WORD_END, 8'h00);
      word_len   = '0;
      scan_phase = SCAN_GAP;
      if (c == CH_LF) begin
        newline_count = newline_count + 1'b1;
        emit_token(KIND_LINE_END, 8'h00);
      end
    end else if (c == CH_BSLASH && !in_escape && quote != QUOTE_SINGLE) begin
      in_escape = 1'b1;
    end else if ((c == CH_SQUOTE || c == CH_DQUOTE) && quote == QUOTE_NONE && !in_escape) begin
      quote = (c == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
    end else if ({1'b0, c} == close_mark && !in_escape) begin
      quote = QUOTE_NONE;
    end else if (c == CH_LF && in_escape) begin
      // line continuation inside a word
      in_escape     = 1'b0;
      newline_count = newline_count + 1'b1;
    end else begin
      // inside double quotes an ordinary escaped byte keeps its backslash
      if (in_escape && quote != QUOTE_NONE && c != CH_BSLASH && {1'b0, c} != close_mark)
        add_char(CH_BSLASH);
      add_char(c);
      in_escape = 1'b0;
      if (c == CH_LF) newline_count = newline_count + 1'b1;
    end
  endtask

  // Handle one byte between words
  task automatic gap_byte(input logic [7:0] c);
    if (c == CH_NUL) begin
      // drop NUL
    end else if (c == CH_LF) begin
      newline_count = newline_count + 1'b1;
      if (in_escape) in_escape = 1'b0;
      else emit_token(KIND_LINE_END, 8'h00);
    end else if (in_escape || (c != CH_HASH && c != CH_BSLASH && !is_blank(c))) begin
      scan_phase = SCAN_WORD;
      word_byte(c);
    end else if (c == CH_HASH) begin
      scan_phase = SCAN_COMMENT;
    end else if (c == CH_BSLASH) begin
      in_escape = 1'b1;
    end
  endtask

  // Predict all result items of one accepted input item
  task automatic predict_item(input logic [7:0] c, input logic eoi);
    token_t t;
    step_tokens = 0;
    if (eoi) begin
      if (scan_phase == SCAN_WORD && (in_escape || quote != QUOTE_NONE)) begin
        emit_token(KIND_ERROR, 8'h00);
      end else begin
        if (scan_phase == SCAN_WORD) emit_token(KIND_WORD_END, 8'h00);
        word_len = '0;
        emit_token(KIND_INPUT_END, 8'h00);
      end
      scan_phase = SCAN_GAP;
      in_escape  = 1'b0;
      quote      = QUOTE_NONE;
      word_len   = '0;
    end else if (scan_phase == SCAN_WORD) begin
      word_byte(c);
    end else if (scan_phase == SCAN_COMMENT) begin
      if (c == CH_LF) begin
        newline_count = newline_count + 1'b1;
        emit_token(KIND_LINE_END, 8'h00);
        scan_phase = SCAN_GAP;
      end
    end else begin
      gap_byte(c);
    end
    // mark the final result of this item
    if (step_tokens > 0) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 30) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Compare one accepted output item with the oldest prediction
  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d", out_kind));
    end else begin
      want = expected_tokens.pop_front();
      checked++;
      if (out_kind !== want.kind)
        report_mismatch($sformatf("result %0d kind %0d, want %0d", checked, out_kind, want.kind));
      if (out_char !== want.ch)
        report_mismatch($sformatf("result %0d char %0h, want %0h", checked, out_char, want.ch));
      if (out_word_length !== want.len)
        report_mismatch($sformatf("result %0d word_length %0d, want %0d",
                                  checked, out_word_length, want.len));
      if (out_line_count !== want.lines)
        report_mismatch($sformatf("result %0d line_count %0d, want %0d",
                                  checked, out_line_count, want.lines));
      if (out_last !== want.last)
        report_mismatch($sformatf("result %0d last %0b, want %0b", checked, out_last, want.last));
    end
  endtask

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      scan_phase    = SCAN_GAP;
      in_escape     = 1'b0;
      quote         = QUOTE_NONE;
      word_len      = '0;
      newline_count = '0;
      expected_tokens.delete();
    end else begin
      if (in_valid && !in_stall) predict_item(in_byte, in_end_of_input);
      if (out_valid && !out_stall) check_token();
    end
    fail_count     <= mismatches;
    tokens_pending <= expected_tokens.size();
    tokens_checked <= checked;
  end

endmodule

>>> dv/shell_quoted_word_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the shell word tokenizer: drives byte streams under several idle
// and stall mixes and gives the verdict. Depends on swt_pkg, swt_token_checker and the tokenizer top.
module shell_quoted_word_tokenizer_unit_tb;
  import swt_pkg::*;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_char;
  logic [11:0] out_word_length;
  logic [15:0] out_line_count;
  logic        out_last;

  int fail_count;
  int tokens_pending;
  int tokens_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  // Pending stimulus: bit 8 marks end of input
  logic [8:0] byte_stream[$];

  shell_quoted_word_tokenizer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_char        (out_char),
    .out_word_length (out_word_length),
    .out_line_count  (out_line_count),
    .out_last        (out_last)
  );

  swt_token_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_char        (out_char),
    .out_word_length (out_word_length),
    .out_line_count  (out_line_count),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .tokens_pending  (tokens_pending),
    .tokens_checked  (tokens_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void push_byte(input logic [7:0] b);
    byte_stream.push_back({1'b0, b});
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_eoi();
    byte_stream.push_back({1'b1, 8'($urandom)});
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Ordinary word character: no quote, backslash, hash, blank or NUL
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH || b == CH_HASH ||
        b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
      b = 8'h61 + (b & 8'h0F);
    return b;
  endfunction

  // Build one well-formed word from plain, quoted and escaped pieces
  function automatic void gen_word();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(3))
        0: repeat ($urandom_range(1, 6)) push_byte(plain_byte());
        1: begin
          push_byte(CH_SQUOTE);
          repeat ($urandom_range(0, 5)) begin
            b = 8'($urandom);
            push_byte(b == CH_SQUOTE ? 8'h78 : b);
          end
          push_byte(CH_SQUOTE);
        end
        2: begin
          push_byte(CH_DQUOTE);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(3) == 0) begin
              push_byte(CH_BSLASH);
              push_byte(8'($urandom));
            end else begin
              b = 8'($urandom);
              push_byte((b == CH_DQUOTE || b == CH_BSLASH) ? 8'h79 : b);
            end
          end
          push_byte(CH_DQUOTE);
        end
        default: begin
          push_byte(CH_BSLASH);
          push_byte(8'($urandom));
        end
      endcase
    end
    if ($urandom_range(99) < 85) push_byte(blank_byte());
  endfunction

  // Add one random chunk: mostly words and separators, some noise
  function automatic void gen_chunk();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      gen_word();
    end else if (roll < 60) begin
      repeat ($urandom_range(1, 3)) push_byte(blank_byte());
    end else if (roll < 68) begin
      push_byte(CH_HASH);
      repeat ($urandom_range(0, 4)) push_byte(plain_byte());
      push_byte(CH_LF);
    end else if (roll < 75) begin
      push_byte(CH_BSLASH);
      push_byte(CH_LF);
    end else if (roll < 90) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    end else if (roll < 95) begin
      push_byte(CH_NUL);
    end else begin
      push_eoi();
    end
  endfunction

  // Offer one item, with a random gap ahead of it, and hold until accepted
  task automatic send_item(input logic [8:0] it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid        <= 1'b1;
    in_byte         <= it[7:0];
    in_end_of_input <= it[8];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Send everything queued, then hold off until all results have come
  task automatic send_and_drain();
    while (byte_stream.size() != 0) send_item(byte_stream.pop_front());
    in_valid <= 1'b0;
    do @(posedge clk); while (tokens_pending != 0);
  endtask

  initial begin
    // hold reset, then release it
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: NUL handling, empty quotes, escapes, comments, end-of-input cases
    idle_pct  = 24;
    stall_pct = 24;
    push_str("a");
    push_byte(CH_NUL);
    push_str("b#c ");
    push_byte(CH_DQUOTE);
    push_byte(CH_DQUOTE);
    push_byte(CH_LF);
    push_byte(CH_SQUOTE);
    push_byte(CH_NUL);
    push_byte(CH_LF);
    push_byte(CH_BSLASH);
    push_byte(CH_SQUOTE);
    push_byte(CH_DQUOTE);
    push_byte(CH_BSLASH);
    push_str("q");
    push_byte(CH_BSLASH);
    push_byte(CH_DQUOTE);
    push_byte(CH_BSLASH);
    push_byte(CH_BSLASH);
    push_byte(CH_DQUOTE);
    push_byte(CH_BSLASH);
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(CH_HASH);
    push_str("z");
    push_byte(CH_LF);
    push_byte(CH_BSLASH);
    push_byte(CH_LF);
    push_byte(8'hFF);
    push_byte(CH_BSLASH);
    push_eoi();
    push_byte(CH_BSLASH);
    push_eoi();
    push_byte(CH_SQUOTE);
    push_eoi();
    send_and_drain();

    // Random streams under each idle and stall mix
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 24 : 0;
      stall_pct = (ph == 2) ? 60 : (ph == 3) ? 24 : 0;
      while (byte_stream.size() < 230) gen_chunk();
      send_and_drain();
    end

    // A long word, then a closing end of input
    idle_pct  = 0;
    stall_pct = 0;
    repeat (100) push_byte(8'h77);
    push_byte(CH_SPACE);
    push_eoi();
    send_and_drain();

    // let any stray result show up
    repeat (20) @(posedge clk);
    $display("Sent %0d input items: directed cases, random word streams and a long word;",
             items_sent);
    $display("checked %0d result items under four handshake mixes", tokens_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/swt_pkg.sv
hdl/swt_front.sv
hdl/swt_queue.sv
hdl/swt_back.sv
hdl/shell_quoted_word_tokenizer_unit.sv
dv/swt_token_checker.sv
dv/shell_quoted_word_tokenizer_unit_tb.sv
